### design/tlbrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbrr_pkg
// Shared types and constants of the TLB refill and replacement block.
// ----------------------------------------------------------------------------
package tlbrr_pkg;

  // default slot count and fixed address geometry
  localparam int ENTRY_COUNT_DEF = 4;
  localparam int ADDR_W          = 32;
  localparam int OFFSET_BITS     = 7;
  localparam int PAGE_W          = ADDR_W - OFFSET_BITS;
  localparam int FRAME_BITS      = 12;
  localparam int IN_FRAME_W      = 12;
  localparam int OUT_FRAME_W     = 12;
  localparam int OUT_SLOT_W      = 2;
  localparam int OUT_PAGE_W      = 25;

  // request codes
  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_FILL   = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_t;

  // replacement policy codes
  typedef enum logic [1:0] {
    POLICY_RR    = 2'd0,
    POLICY_FIFO  = 2'd1,
    POLICY_CLOCK = 2'd2
  } policy_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EXEC
  } state_t;

  // input item
  typedef struct packed {
    logic [1:0]            req_type;
    logic [ADDR_W-1:0]     virt_addr;
    logic [IN_FRAME_W-1:0] frame_number;
    logic                  page_dirty;
    logic                  page_read_only;
    logic                  page_use;
  } tlbrr_in_t;

  // result item
  typedef struct packed {
    logic                   hit;
    logic [OUT_FRAME_W-1:0] out_frame;
    logic [OUT_SLOT_W-1:0]  slot_index;
    logic                   evicted;
    logic [OUT_PAGE_W-1:0]  evicted_page;
  } tlbrr_out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic sweep_step;
    logic execute;
  } tlbrr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clock_fill;
    logic sweep_stop;
  } tlbrr_sts_t;

endpackage

### design/tlbrr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbrr_ctrl
// Sequencer: takes one item, runs the clock sweep when needed, then executes
// the request into the output register once that register is free.
// ----------------------------------------------------------------------------
module tlbrr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  tlbrr_pkg::tlbrr_sts_t sts,
  output tlbrr_pkg::tlbrr_cmd_t cmd
);
  import tlbrr_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.clock_fill ? ST_SWEEP : ST_EXEC;
        end
      end
      ST_SWEEP: begin
        if (sts.sweep_stop) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_SWEEP: begin
        cmd.sweep_step = !sts.sweep_stop;
      end
      ST_EXEC: begin
        cmd.execute = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // result register occupancy
  assign out_valid_nxt = cmd.execute ? 1'b1 : (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/tlbrr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbrr_dp
// Slot storage, policy register, hand pointer, lookup match and the
// replacement update, plus the registered result.
// ----------------------------------------------------------------------------
module tlbrr_dp #(
  parameter int ENTRY_COUNT = tlbrr_pkg::ENTRY_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tlbrr_pkg::tlbrr_in_t  in_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_data,
  input  tlbrr_pkg::tlbrr_cmd_t cmd,
  output tlbrr_pkg::tlbrr_sts_t sts,
  output tlbrr_pkg::tlbrr_out_t out_data
);
  import tlbrr_pkg::*;

  localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int SLX_W = (IDX_W > OUT_SLOT_W) ? IDX_W : OUT_SLOT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

  // configuration
  policy_t policy_r;

  // captured item
  logic [1:0]            it_req_r;
  logic [PAGE_W-1:0]     it_page_r;
  logic [FRAME_BITS-1:0] it_frame_r;
  logic                  it_dirty_r;
  logic                  it_ro_r;
  logic                  it_use_r;

  // slot state
  logic [ENTRY_COUNT-1:0] valid_r, valid_nxt;
  logic [ENTRY_COUNT-1:0] use_r, use_nxt;
  logic [ENTRY_COUNT-1:0] dirty_r, dirty_nxt;
  logic [ENTRY_COUNT-1:0] ro_r, ro_nxt;
  logic [PAGE_W-1:0]      page_r [ENTRY_COUNT];
  logic [PAGE_W-1:0]      page_nxt [ENTRY_COUNT];
  logic [FRAME_BITS-1:0]  frame_r [ENTRY_COUNT];
  logic [FRAME_BITS-1:0]  frame_nxt [ENTRY_COUNT];
  logic [IDX_W-1:0]       hand_r, hand_nxt, hand_inc;

  // result
  tlbrr_out_t res_r, res_nxt;

  // hand pointer wraps at the slot count
  assign hand_inc = (hand_r == LAST_IDX) ? '0 : IDX_W'(hand_r + 1'b1);

  // status toward the sequencer
  assign sts.clock_fill = (in_data.req_type == REQ_FILL) && (policy_r == POLICY_CLOCK);
  assign sts.sweep_stop = !valid_r[hand_r] || !use_r[hand_r];

  // policy register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_RR;
    end else if (cfg_we) begin
      policy_r <= policy_t'(cfg_data);
    end
  end

  // item capture on input transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_req_r   <= in_data.req_type;
      it_page_r  <= PAGE_W'(in_data.virt_addr >> OFFSET_BITS);
      it_frame_r <= FRAME_BITS'(in_data.frame_number);
      it_dirty_r <= in_data.page_dirty;
      it_ro_r    <= in_data.page_read_only;
      it_use_r   <= in_data.page_use;
    end
  end

  // sweep step and request execution
  always_comb begin
    logic             found;
    logic [IDX_W-1:0] sel;
    logic [SLX_W-1:0] sel_ext;
    logic             put;
    logic             put_use;
    valid_nxt = valid_r;
    use_nxt   = use_r;
    dirty_nxt = dirty_r;
    ro_nxt    = ro_r;
    page_nxt  = page_r;
    frame_nxt = frame_r;
    hand_nxt  = hand_r;
    res_nxt   = res_r;
    found     = 1'b0;
    sel       = '0;
    sel_ext   = '0;
    put       = 1'b0;
    put_use   = it_use_r;

    // clock sweep: give a used slot its second chance
    if (cmd.sweep_step) begin
      use_nxt[hand_r] = 1'b0;
      hand_nxt        = hand_inc;
    end

    if (cmd.execute) begin
      res_nxt = '0;
      unique case (req_t'(it_req_r))
        REQ_LOOKUP: begin
          // lowest matching valid slot answers
          for (int i = 0; i < ENTRY_COUNT; i++) begin
            if (!found && valid_r[i] && (page_r[i] == it_page_r)) begin
              found = 1'b1;
              sel   = IDX_W'(i);
            end
          end
          if (found) begin
            use_nxt[sel]      = 1'b1;
            res_nxt.hit       = 1'b1;
            res_nxt.out_frame = OUT_FRAME_W'(frame_r[sel]);
            sel_ext           = SLX_W'(sel);
            res_nxt.slot_index = sel_ext[OUT_SLOT_W-1:0];
          end
        end
        REQ_FILL: begin
          put = 1'b1;
          priority case (policy_r)
            POLICY_FIFO: begin
              // first free slot, else shift everything down one
              for (int i = 0; i < ENTRY_COUNT; i++) begin
                if (!found && !valid_r[i]) begin
                  found = 1'b1;
                  sel   = IDX_W'(i);
                end
              end
              if (!found) begin
                res_nxt.evicted      = 1'b1;
                res_nxt.evicted_page = OUT_PAGE_W'(page_r[0]);
                for (int i = 0; i < ENTRY_COUNT - 1; i++) begin
                  valid_nxt[i] = valid_r[i+1];
                  use_nxt[i]   = use_r[i+1];
                  dirty_nxt[i] = dirty_r[i+1];
                  ro_nxt[i]    = ro_r[i+1];
                  page_nxt[i]  = page_r[i+1];
                  frame_nxt[i] = frame_r[i+1];
                end
                sel = LAST_IDX;
              end
            end
            POLICY_CLOCK: begin
              // sweep already parked the hand on the victim
              sel     = hand_r;
              put_use = 1'b1;
              if (valid_r[sel]) begin
                res_nxt.evicted      = 1'b1;
                res_nxt.evicted_page = OUT_PAGE_W'(page_r[sel]);
              end
            end
            default: begin
              // round robin, also for the unused policy code
              sel      = hand_r;
              hand_nxt = hand_inc;
              if (valid_r[sel]) begin
                res_nxt.evicted      = 1'b1;
                res_nxt.evicted_page = OUT_PAGE_W'(page_r[sel]);
              end
            end
          endcase
          res_nxt.out_frame  = OUT_FRAME_W'(it_frame_r);
          sel_ext            = SLX_W'(sel);
          res_nxt.slot_index = sel_ext[OUT_SLOT_W-1:0];
        end
        REQ_FLUSH: begin
          valid_nxt = '0;
        end
        default: begin
          valid_nxt = valid_r;
        end
      endcase

      // write the new entry
      if (put) begin
        valid_nxt[sel] = 1'b1;
        use_nxt[sel]   = put_use;
        dirty_nxt[sel] = it_dirty_r;
        ro_nxt[sel]    = it_ro_r;
        page_nxt[sel]  = it_page_r;
        frame_nxt[sel] = it_frame_r;
      end
    end
  end

  // slot flags and hand pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      use_r   <= '0;
      dirty_r <= '0;
      ro_r    <= '0;
      hand_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      use_r   <= use_nxt;
      dirty_r <= dirty_nxt;
      ro_r    <= ro_nxt;
      hand_r  <= hand_nxt;
    end
  end

  // slot payload and result register
  always_ff @(posedge clk) begin
    page_r  <= page_nxt;
    frame_r <= frame_nxt;
    res_r   <= res_nxt;
  end

  assign out_data = res_r;

endmodule

### design/tlb_refill_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_refill_replacement
// Small fully associative TLB with lookup, fill and flush requests and a
// selectable replacement policy: round robin, FIFO with shift, or clock.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake        payload
//   in_       input      valid / stall    tlbrr_in_t  (request)
//   out_      output     valid / stall    tlbrr_out_t (result)
//   cfg_      input      valid / ready    policy_mode (2 bits)
//
// Lookup, flush and round robin or FIFO fill go from the input transfer to the
// execute step; a clock fill first sweeps the hand pointer over the slots,
// clearing the use bit of each used slot it passes, and then executes.
// One request is in work at a time; a new one is taken while the previous
// result still waits in the output register. A stalled output holds the
// next request in its execute step. Synchronous active-low reset clears all
// slot flags, the hand pointer and the policy; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tlb_refill_replacement #(
  parameter int ENTRY_COUNT = tlbrr_pkg::ENTRY_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tlbrr_pkg::tlbrr_in_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tlbrr_pkg::tlbrr_out_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_data
);
  import tlbrr_pkg::*;

  tlbrr_cmd_t cmd;
  tlbrr_sts_t sts;

  // policy writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer
  tlbrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // slot storage and replacement datapath
  tlbrr_dp #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
